// ===== hw/rtl/bms_pkg.sv =====
// Package for the bracket match scanner: widths, bracket codes and result
// status codes. No dependencies; used by bracket_match_scanner_core.
`default_nettype none

package bms_pkg;

  localparam int POS_BITS    = 20;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CHAR_W      = 21;
  localparam int DEPTH_W     = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_POS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IS_OPENER  = 2'd2;

  typedef enum logic [1:0] {
    PAIR_CURLY  = 2'd0,
    PAIR_PAREN  = 2'd1,
    PAIR_SQUARE = 2'd2,
    PAIR_NONE   = 2'd3
  } pair_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  localparam logic [CHAR_W-1:0] CH_LCURLY  = 21'h00007B;
  localparam logic [CHAR_W-1:0] CH_RCURLY  = 21'h00007D;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 21'h000028;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 21'h000029;
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 21'h00005B;
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 21'h00005D;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // The unused kind matches no character.
  function automatic logic is_opener(input pair_t pair, input logic [CHAR_W-1:0] ch);
    logic hit;
    hit = 1'b0;
    case (pair)
      PAIR_CURLY:  hit = (ch == CH_LCURLY);
      PAIR_PAREN:  hit = (ch == CH_LPAREN);
      PAIR_SQUARE: hit = (ch == CH_LSQUARE);
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_closer(input pair_t pair, input logic [CHAR_W-1:0] ch);
    logic hit;
    hit = 1'b0;
    case (pair)
      PAIR_CURLY:  hit = (ch == CH_RCURLY);
      PAIR_PAREN:  hit = (ch == CH_RPAREN);
      PAIR_SQUARE: hit = (ch == CH_RSQUARE);
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bracket_match_scanner_core.sv =====
// Path: a request is registered in the input stage, then the decision stage, then the output stage.
// Throughput: one character per cycle unless out_tready stalls; the stack memory has one
// write and one registered read port, and the read for a match goes out with the decision.
// Reset: synchronous, active low; clears scan state, pipeline valids and sets
// the registers to anchor 0, curly braces, opener mode. The stack needs no clearing.
// Depends on bms_pkg.
`default_nettype none

module bracket_match_scanner_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [bms_pkg::IN_DATA_W-1:0]       in_tdata,   // [20:0] char_code, rest zero
  input  wire                                 in_tuser,   // [0] in_skip
  input  wire                                 in_tlast,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [bms_pkg::OUT_DATA_W-1:0]      out_tdata,  // [1:0] match_status,
                                                          // [21:2] match_position, rest zero
  input  wire                                 cfg_we,
  input  wire  [bms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [bms_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int PW = bms_pkg::POS_BITS;
  localparam int AW = bms_pkg::ADDR_W;
  localparam int CW = bms_pkg::CNT_W;
  localparam int DW = bms_pkg::DEPTH_W;

  // Configuration registers.
  logic [PW-1:0]          anchor_pos_r;
  bms_pkg::pair_t         pair_r;
  logic                   is_opener_r;

  // Input stage.
  logic                       s1_valid_r;
  logic [bms_pkg::CHAR_W-1:0] s1_char_r;
  logic                       s1_skip_r;
  logic                       s1_last_r;

  // Scan state.
  logic [PW-1:0] scan_pos_r, scan_pos_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          anchor_seen_r, anchor_seen_nxt;
  logic [CW-1:0] stack_count_r, stack_count_nxt;
  logic          overflow_r, overflow_nxt;
  logic          decided_r, decided_nxt;

  // Stack memory.
  logic [PW-1:0] stack_mem [bms_pkg::STACK_DEPTH];
  logic [PW-1:0] stack_rdata_r;
  logic          push;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Decision stage.
  logic              s2_valid_r, s2_valid_nxt;
  bms_pkg::status_t  s2_status_r;
  logic [PW-1:0]     s2_pos_r;
  logic              s2_use_mem_r;

  // Output stage.
  logic              out_valid_r;
  bms_pkg::status_t  out_status_r;
  logic [PW-1:0]     out_pos_r;

  logic              out_free, s2_go, s2_free, s1_step, in_acc;
  logic              emit, use_mem, ch_open, ch_close, at_anchor;
  bms_pkg::status_t  status;
  logic [PW-1:0]     where;
  logic [DW-1:0]     depth_dec;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_go     = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_step   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_acc    = in_tvalid && in_tready;

  assign ch_open   = bms_pkg::is_opener(pair_r, s1_char_r);
  assign ch_close  = bms_pkg::is_closer(pair_r, s1_char_r);
  assign at_anchor = (scan_pos_r == anchor_pos_r);
  assign count_dec = stack_count_r - CW'(1);
  assign rd_addr   = count_dec[AW-1:0];
  assign wr_addr   = stack_count_r[AW-1:0];

  always_comb begin
    scan_pos_nxt    = scan_pos_r;
    depth_nxt       = depth_r;
    anchor_seen_nxt = anchor_seen_r;
    stack_count_nxt = stack_count_r;
    overflow_nxt    = overflow_r;
    decided_nxt     = decided_r;
    emit            = 1'b0;
    use_mem         = 1'b0;
    push            = 1'b0;
    status          = bms_pkg::ST_NO_MATCH;
    where           = '0;
    depth_dec       = (depth_r != '0) ? depth_r - DW'(1) : depth_r;
    if (!decided_r && !s1_skip_r) begin
      if (is_opener_r) begin
        if (ch_open) begin
          if (at_anchor) begin
            anchor_seen_nxt = 1'b1;
            depth_nxt       = DW'(1);
          end else if (anchor_seen_r && depth_r != bms_pkg::DEPTH_MAX) begin
            depth_nxt = depth_r + DW'(1);
          end
        end else if (ch_close && anchor_seen_r) begin
          depth_nxt = depth_dec;
          if (depth_dec == '0) begin
            emit   = 1'b1;
            status = bms_pkg::ST_FOUND;
            where  = scan_pos_r;
          end
        end
      end else begin
        if (ch_open) begin
          if (stack_count_r < CW'(bms_pkg::STACK_DEPTH)) begin
            push            = 1'b1;
            stack_count_nxt = stack_count_r + CW'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
        end else if (ch_close) begin
          if (at_anchor) begin
            emit = 1'b1;
            if (overflow_r) begin
              status = bms_pkg::ST_OVERFLOW;
            end else if (stack_count_r == '0) begin
              status = bms_pkg::ST_NO_MATCH;
            end else begin
              status  = bms_pkg::ST_FOUND;
              use_mem = 1'b1;
            end
          end else if (stack_count_r != '0) begin
            stack_count_nxt = count_dec;
          end
        end
      end
    end
    if (emit) begin
      decided_nxt = 1'b1;
    end
    if (s1_last_r && !decided_nxt) begin
      emit    = 1'b1;
      status  = bms_pkg::ST_NO_MATCH;
      where   = '0;
      use_mem = 1'b0;
    end
    if (s1_last_r) begin
      scan_pos_nxt    = '0;
      depth_nxt       = '0;
      anchor_seen_nxt = 1'b0;
      stack_count_nxt = '0;
      overflow_nxt    = 1'b0;
      decided_nxt     = 1'b0;
    end else begin
      scan_pos_nxt = scan_pos_r + PW'(1);
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s1_step) begin
      s2_valid_nxt = emit;
    end else if (s2_go) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_pos_r <= '0;
      pair_r       <= bms_pkg::PAIR_CURLY;
      is_opener_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bms_pkg::REG_ANCHOR_POS: anchor_pos_r <= cfg_wdata[PW-1:0];
        bms_pkg::REG_PAIR:       pair_r       <= bms_pkg::pair_t'(cfg_wdata[1:0]);
        bms_pkg::REG_IS_OPENER:  is_opener_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      scan_pos_r    <= '0;
      depth_r       <= '0;
      anchor_seen_r <= 1'b0;
      stack_count_r <= '0;
      overflow_r    <= 1'b0;
      decided_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_step) begin
        s1_valid_r <= 1'b0;
      end
      s2_valid_r <= s2_valid_nxt;
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_step) begin
        scan_pos_r    <= scan_pos_nxt;
        depth_r       <= depth_nxt;
        anchor_seen_r <= anchor_seen_nxt;
        stack_count_r <= stack_count_nxt;
        overflow_r    <= overflow_nxt;
        decided_r     <= decided_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_tdata[bms_pkg::CHAR_W-1:0];
      s1_skip_r <= in_tuser;
      s1_last_r <= in_tlast;
    end
    if (s1_step) begin
      s2_status_r  <= status;
      s2_pos_r     <= where;
      s2_use_mem_r <= use_mem;
    end
    if (s2_go) begin
      out_status_r <= s2_status_r;
      out_pos_r    <= s2_use_mem_r ? stack_rdata_r : s2_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && push) begin
      stack_mem[wr_addr] <= scan_pos_r;
    end
    if (s1_step) begin
      stack_rdata_r <= stack_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bms_pkg::OUT_DATA_W - PW - 2){1'b0}}, out_pos_r, out_status_r};

`ifndef SYNTHESIS
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != bms_pkg::ST_RSVD))
    else $error("reserved status code on output");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_count_r <= CW'(bms_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_decision_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_step && emit && !s1_last_r) |=> decided_r)
    else $error("decision not recorded after a result");

  a_mem_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_use_mem_r) |-> (s2_status_r == bms_pkg::ST_FOUND))
    else $error("stack read used for a result that is not a match");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire
